/* sv/fdd_pkg.sv */
// Shared types and constants for the finite difference derivative block.
`default_nettype none

package fdd_pkg;

    localparam int SAMPLE_W  = 32;
    localparam int RECIP_W   = 32;
    localparam int HALF_W    = 16;
    localparam int POINT_W   = 16;
    localparam int DER_W     = 48;
    // Widest stencil has weight sum 12, so 32 + 4 bits hold every difference.
    localparam int DIFF_W    = 36;
    localparam int PROD_W    = DIFF_W + HALF_W;
    localparam int SCALED_W  = PROD_W + 1;
    localparam int JOB_DEPTH = 4;
    localparam int OUT_DEPTH = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [RECIP_W-1:0]  RECIP_RESET = 32'h0001_0000;
    localparam logic [PROD_W-1:0]   ROUND_HALF  = PROD_W'(32'h0000_8000);
    localparam logic [DER_W-1:0]    DER_MAX     = 48'h7FFF_FFFF_FFFF;
    localparam logic [DER_W-1:0]    DER_MIN     = 48'h8000_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RECIP_TWO_STEP     = 1'b0,
        REG_RECIP_STEP_SQUARED = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_sample;
    } sample_t;

    typedef struct packed {
        logic [POINT_W-1:0]      point_index;
        logic signed [DER_W-1:0] first_derivative;
        logic signed [DER_W-1:0] second_derivative;
        logic                    end_of_run;
        logic                    too_short;
    } result_t;

    // One result still to be scaled: the raw stencil differences.
    typedef struct packed {
        logic [POINT_W-1:0]       point_index;
        logic signed [DIFF_W-1:0] diff1;
        logic signed [DIFF_W-1:0] diff2;
        logic                     end_of_run;
        logic                     too_short;
    } job_t;

endpackage

`default_nettype wire

/* sv/finite_difference_derivatives.sv */
// Top level of the streaming first and second derivative block.
// Samples are taken one per cycle in the steady state while the job queue has
// room. From the third sample of a run on, each sample yields one result (its
// central difference for the previous index); the fourth sample and the last of
// a run of four or more yield two or three, and full then stays high while the
// front end hands those results one beat per cycle to the job queue, as it has
// room. Each result passes through the three-stage scaling pipeline (magnitude,
// split 36x16 products, rounding sum) with saturation at the result queue.
// Results come out in index order, except that index 0 follows index 1.
`default_nettype none

module finite_difference_derivatives #(
    parameter int MAX_POINTS = 65536
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire fdd_pkg::sample_t              sample_beat,
    output logic                               empty,
    input  wire logic                          pop,
    output fdd_pkg::result_t                   result,
    input  wire logic                          cfg_we,
    input  wire logic [fdd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [fdd_pkg::RECIP_W-1:0]   cfg_data
);

    import fdd_pkg::*;

    job_t                           front_job;
    logic                           front_push;
    logic                           job_full;
    job_t                           back_job;
    logic                           job_empty;
    logic                           job_pop;
    logic                           out_push;
    result_t                        out_result;
    logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

    fdd_front #(
        .MAX_POINTS(MAX_POINTS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .sample_beat (sample_beat),
        .job_push    (front_push),
        .job         (front_job),
        .job_full    (job_full)
    );

    fdd_fifo #(
        .WIDTH($bits(job_t)),
        .DEPTH(JOB_DEPTH)
    ) u_job_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .push_data (front_job),
        .pop       (job_pop),
        .pop_data  (back_job),
        .full      (job_full),
        .empty     (job_empty),
        .count     ()
    );

    fdd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .job        (back_job),
        .job_empty  (job_empty),
        .job_pop    (job_pop),
        .out_count  (out_count),
        .out_push   (out_push),
        .out_result (out_result)
    );

    fdd_fifo #(
        .WIDTH($bits(result_t)),
        .DEPTH(OUT_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (out_push),
        .push_data (out_result),
        .pop       (pop),
        .pop_data  (result),
        .full      (),
        .empty     (empty),
        .count     (out_count)
    );

endmodule

`default_nettype wire

/* sv/fdd_fifo.sv */
// Small register-based FIFO with occupancy count.
`default_nettype none

module fdd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    input  wire logic [WIDTH-1:0]               push_data,
    input  wire logic                           pop,
    output logic      [WIDTH-1:0]               pop_data,
    output logic                                full,
    output logic                                empty,
    output logic      [$clog2(DEPTH+1)-1:0]     count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign count    = count_reg;
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* sv/fdd_front.sv */
// Front end: sample window, index tracking and stencil differences per result.
`default_nettype none

module fdd_front #(
    parameter int MAX_POINTS = 65536
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire fdd_pkg::sample_t sample_beat,
    output logic                  job_push,
    output fdd_pkg::job_t         job,
    input  wire logic             job_full
);

    import fdd_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS);

    logic signed [SAMPLE_W-1:0] w0_reg, w1_reg, w2_reg;
    logic [CNT_W-1:0]           cnt_reg;
    job_t                       slot_reg [3];
    job_t                       slot_next [3];
    logic [1:0]                 pend_reg, pend_next;

    logic                       accept;
    logic                       is_last;
    logic                       is_short;
    logic                       has_fwd;
    logic                       has_cen;
    logic [POINT_W-1:0]         pt_k;
    logic signed [DIFF_W-1:0]   x0, x1, x2, x3;
    logic signed [DIFF_W-1:0]   fwd1, fwd2, cen1, cen2, bwd1, bwd2;
    job_t                       fwd_job, cen_job, bwd_job, short_job;
    job_t                       new_slot [3];
    logic [1:0]                 new_cnt;

    // A bundle of two or three results drains one beat per cycle while the job
    // queue has room; the next sample waits until at most one result remains.
    assign full     = (pend_reg > 2'd1) || ((pend_reg == 2'd1) && job_full);
    assign accept   = push && !full;
    assign job_push = (pend_reg != 2'd0) && !job_full;
    assign job      = slot_reg[0];

    assign is_last  = sample_beat.last_sample || (cnt_reg >= CNT_W'(MAX_POINTS - 1));
    assign is_short = is_last && (cnt_reg < CNT_W'(3));
    assign has_fwd  = (cnt_reg == CNT_W'(3));
    assign has_cen  = (cnt_reg >= CNT_W'(2));
    assign pt_k     = POINT_W'(cnt_reg);

    // Window after the shift: x0 newest, x3 oldest.
    assign x0 = DIFF_W'(sample_beat.sample);
    assign x1 = DIFF_W'(w0_reg);
    assign x2 = DIFF_W'(w1_reg);
    assign x3 = DIFF_W'(w2_reg);

    assign fwd1 = (x2 <<< 2) - (x3 <<< 1) - x3 - x1;
    assign fwd2 = (x3 <<< 1) - (x2 <<< 2) - x2 + (x1 <<< 2) - x0;
    assign cen1 = x0 - x2;
    assign cen2 = x2 - (x1 <<< 1) + x0;
    assign bwd1 = x2 - (x1 <<< 2) + (x0 <<< 1) + x0;
    assign bwd2 = (x2 <<< 2) - x3 - (x1 <<< 2) - x1 + (x0 <<< 1);

    assign fwd_job   = '{point_index: '0, diff1: fwd1, diff2: fwd2,
                         end_of_run: 1'b0, too_short: 1'b0};
    assign cen_job   = '{point_index: pt_k - 1'b1, diff1: cen1, diff2: cen2,
                         end_of_run: 1'b0, too_short: 1'b0};
    assign bwd_job   = '{point_index: pt_k, diff1: bwd1, diff2: bwd2,
                         end_of_run: 1'b1, too_short: 1'b0};
    assign short_job = '{point_index: '0, diff1: '0, diff2: '0,
                         end_of_run: 1'b1, too_short: 1'b1};

    // The forward result needs the fourth sample, which always also gives a
    // central result, so results are ordered forward, central, backward.
    always_comb
    begin
        new_slot[0] = cen_job;
        new_slot[1] = bwd_job;
        new_slot[2] = bwd_job;
        new_cnt     = 2'd0;
        if (is_short)
        begin
            new_slot[0] = short_job;
            new_cnt     = 2'd1;
        end
        else if (has_fwd)
        begin
            new_slot[0] = fwd_job;
            new_slot[1] = cen_job;
            new_cnt     = is_last ? 2'd3 : 2'd2;
        end
        else if (has_cen)
        begin
            new_cnt = is_last ? 2'd2 : 2'd1;
        end
    end

    always_comb
    begin
        slot_next[0] = slot_reg[0];
        slot_next[1] = slot_reg[1];
        slot_next[2] = slot_reg[2];
        pend_next    = pend_reg;
        if (job_push)
        begin
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
            pend_next    = pend_reg - 1'b1;
        end
        if (accept)
        begin
            slot_next[0] = new_slot[0];
            slot_next[1] = new_slot[1];
            slot_next[2] = new_slot[2];
            pend_next    = new_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w0_reg   <= '0;
            w1_reg   <= '0;
            w2_reg   <= '0;
            cnt_reg  <= '0;
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (accept)
            begin
                if (is_last)
                begin
                    w0_reg  <= '0;
                    w1_reg  <= '0;
                    w2_reg  <= '0;
                    cnt_reg <= '0;
                end
                else
                begin
                    w0_reg  <= sample_beat.sample;
                    w1_reg  <= w0_reg;
                    w2_reg  <= w1_reg;
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
        slot_reg[2] <= slot_next[2];
    end

endmodule

`default_nettype wire

/* sv/fdd_back.sv */
// Back end: reciprocal scaling, rounding and 48-bit saturation of each result.
`default_nettype none

module fdd_back (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [fdd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [fdd_pkg::RECIP_W-1:0]      cfg_data,
    input  wire fdd_pkg::job_t                    job,
    input  wire logic                             job_empty,
    output logic                                  job_pop,
    input  wire logic [$clog2(fdd_pkg::OUT_DEPTH+1)-1:0] out_count,
    output logic                                  out_push,
    output fdd_pkg::result_t                      out_result
);

    import fdd_pkg::*;

    localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic [POINT_W-1:0] point_index;
        logic               end_of_run;
        logic               too_short;
        logic               neg1;
        logic               neg2;
    } tag_t;

    logic [RECIP_W-1:0]  recip1_reg, recip2_reg;

    logic                v1_reg, v2_reg, v3_reg;
    tag_t                tag1_reg, tag2_reg, tag3_reg;
    logic [DIFF_W-1:0]   mag1_reg, mag2_reg;
    logic [PROD_W-1:0]   p1h_reg, p1l_reg, p2h_reg, p2l_reg;
    logic [SCALED_W-1:0] r1_reg, r2_reg;
    logic [SCALED_W-1:0] r1_next, r2_next;
    logic [OCNT_W:0]     credit_sum;

    function automatic logic [DER_W-1:0] saturate(input logic [SCALED_W-1:0] r,
                                                  input logic neg);
        logic [DER_W-1:0] res;
        if (!neg)
        begin
            res = (r > SCALED_W'(DER_MAX)) ? DER_MAX : r[DER_W-1:0];
        end
        else
        begin
            res = (r > SCALED_W'(DER_MIN)) ? DER_MIN : (~r[DER_W-1:0] + 1'b1);
        end
        return res;
    endfunction

    // A job leaves the queue only when the output queue has room for it and
    // for every result still in the pipeline.
    assign credit_sum = (OCNT_W + 1)'(out_count) + (OCNT_W + 1)'(v1_reg)
                      + (OCNT_W + 1)'(v2_reg) + (OCNT_W + 1)'(v3_reg);
    assign job_pop    = !job_empty && (credit_sum < (OCNT_W + 1)'(OUT_DEPTH));

    // Rounding half away from zero is done on the magnitude.
    assign r1_next = SCALED_W'(p1h_reg) + SCALED_W'((p1l_reg + ROUND_HALF) >> HALF_W);
    assign r2_next = SCALED_W'(p2h_reg) + SCALED_W'((p2l_reg + ROUND_HALF) >> HALF_W);

    assign out_push = v3_reg;
    assign out_result = '{point_index:       tag3_reg.point_index,
                          first_derivative:  saturate(r1_reg, tag3_reg.neg1),
                          second_derivative: saturate(r2_reg, tag3_reg.neg2),
                          end_of_run:        tag3_reg.end_of_run,
                          too_short:         tag3_reg.too_short};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recip1_reg <= RECIP_RESET;
            recip2_reg <= RECIP_RESET;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_RECIP_TWO_STEP:     recip1_reg <= cfg_data;
                    REG_RECIP_STEP_SQUARED: recip2_reg <= cfg_data;
                    default:                ;
                endcase
            end
            v1_reg <= job_pop;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        tag1_reg <= '{point_index: job.point_index, end_of_run: job.end_of_run,
                      too_short: job.too_short, neg1: job.diff1[DIFF_W-1],
                      neg2: job.diff2[DIFF_W-1]};
        mag1_reg <= job.diff1[DIFF_W-1] ? (~job.diff1 + 1'b1) : job.diff1;
        mag2_reg <= job.diff2[DIFF_W-1] ? (~job.diff2 + 1'b1) : job.diff2;

        tag2_reg <= tag1_reg;
        p1h_reg  <= mag1_reg * recip1_reg[RECIP_W-1:HALF_W];
        p1l_reg  <= mag1_reg * recip1_reg[HALF_W-1:0];
        p2h_reg  <= mag2_reg * recip2_reg[RECIP_W-1:HALF_W];
        p2l_reg  <= mag2_reg * recip2_reg[HALF_W-1:0];

        tag3_reg <= tag2_reg;
        r1_reg   <= r1_next;
        r2_reg   <= r2_next;
    end

endmodule

`default_nettype wire

/* sv/fdd_checker.sv */
// Port-level checks on the result side of the derivative block.
`default_nettype none

module fdd_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             pop,
    input wire logic             empty,
    input wire fdd_pkg::result_t result
);

    import fdd_pkg::*;

    // A short run closes with exactly one beat, which also ends the run.
    a_short_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.too_short) |-> result.end_of_run)
        else $error("too_short beat without end_of_run");

    a_short_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.too_short) |->
            (result.point_index == '0) && (result.first_derivative == '0)
            && (result.second_derivative == '0))
        else $error("too_short beat carries nonzero index or derivatives");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed or vanished");

endmodule

bind finite_difference_derivatives fdd_checker u_fdd_checker (.*);

`default_nettype wire
